/* src/cdq_pkg.sv */
// Shared types and constants for the circular deque unit.
// Holds the request and response structs, action and status codes.
// No dependencies.
package cdq_pkg;

  localparam int unsigned DepthDefault    = 16;
  localparam int unsigned WordBitsDefault = 32;
  localparam int unsigned DataW           = 32;
  localparam int unsigned CountW          = 5;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_BACK  = 3'd5,
    ACT_CLEAR      = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]              action;
    logic signed [DataW-1:0] value;
  } cdq_req_t;

  typedef struct packed {
    logic signed [DataW-1:0] data;
    logic [1:0]              status;
    logic [CountW-1:0]       count;
    logic                    empty_flag;
    logic                    full_flag;
  } cdq_rsp_t;

endpackage

/* src/cdq_ring.sv */
// Ring store of the circular deque: one write port and one read port.
// The read data is registered, so it appears in the cycle after the read.
// No package dependencies.
module cdq_ring #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr_i,
  input  logic [WORD_BITS-1:0]         wr_data_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr_i,
  output logic [WORD_BITS-1:0]         rd_data_o
);

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/circular_deque_unit.sv */
// Top level of the circular deque: pointers, count, control and result register.
// Depends on cdq_pkg and instantiates cdq_ring for the word store.
//
//   Channel | Valid       | Stall       | Payload
//   --------+-------------+-------------+-----------------------
//   request | in_valid_i  | in_stall_o  | in_req_i   (cdq_req_t)
//   result  | out_valid_o | out_stall_i | out_rsp_o  (cdq_rsp_t)
//
// Push, clear, unknown actions and a pop or peek on an empty deque fill the result
// register directly; a pop or peek that reads a word waits in ST_READ for the read
// port of the ring store. A new request is taken while the result register drains.
// Reset clears the pointers, the count and the control; the store is not cleared.
// A stalled result holds the request channel until the result is taken.
module circular_deque_unit #(
  parameter int unsigned DEPTH     = cdq_pkg::DepthDefault,
  parameter int unsigned WORD_BITS = cdq_pkg::WordBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cdq_pkg::cdq_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cdq_pkg::cdq_rsp_t out_rsp_o
);

  import cdq_pkg::*;

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [AddrW-1:0]  front_q, front_d;
  logic [AddrW-1:0]  back_q, back_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              out_valid_q, out_valid_d;
  cdq_rsp_t          rsp_q, rsp_d;

  logic              accept;
  logic              is_empty;
  logic              is_full;
  logic              need_rd;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [AddrW-1:0]  rd_addr;
  logic [1:0]        status;
  logic signed [DataW-1:0] imm_data;
  logic [CntW+CountW-1:0]  count_wide;
  logic [WORD_BITS-1:0]    wr_word;
  logic [WORD_BITS-1:0]    rd_word;
  logic signed [DataW-1:0] rd_data;

  function automatic logic [AddrW-1:0] step_up(input logic [AddrW-1:0] p);
    step_up = (p == AddrW'(DEPTH - 1)) ? '0 : p + AddrW'(1);
  endfunction

  function automatic logic [AddrW-1:0] step_down(input logic [AddrW-1:0] p);
    step_down = (p == '0) ? AddrW'(DEPTH - 1) : p - AddrW'(1);
  endfunction

  generate
    if (WORD_BITS <= DataW) begin : g_narrow_wr
      assign wr_word = in_req_i.value[WORD_BITS-1:0];
    end else begin : g_wide_wr
      assign wr_word = {{(WORD_BITS - DataW){in_req_i.value[DataW-1]}}, in_req_i.value};
    end
    if (WORD_BITS >= DataW) begin : g_wide_rd
      assign rd_data = rd_word[DataW-1:0];
    end else begin : g_narrow_rd
      assign rd_data = {{(DataW - WORD_BITS){rd_word[WORD_BITS-1]}}, rd_word};
    end
  endgenerate

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_empty   = (count_q == '0);
  assign is_full    = (count_q == CntW'(DEPTH));

  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    count_d  = count_q;
    status   = STAT_OK;
    need_rd  = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = back_q;
    rd_addr  = front_q;
    unique case (in_req_i.action) inside
      ACT_PUSH_FRONT: begin
        if (is_full) begin
          status = STAT_FULL;
        end else begin
          front_d = step_down(front_q);
          wr_en   = 1'b1;
          wr_addr = step_down(front_q);
          count_d = count_q + CntW'(1);
        end
      end
      ACT_PUSH_BACK: begin
        if (is_full) begin
          status = STAT_FULL;
        end else begin
          back_d  = step_up(back_q);
          wr_en   = 1'b1;
          wr_addr = back_q;
          count_d = count_q + CntW'(1);
        end
      end
      ACT_POP_FRONT, ACT_PEEK_FRONT: begin
        if (is_empty) begin
          status = STAT_EMPTY;
        end else begin
          need_rd = 1'b1;
          rd_addr = front_q;
          if (action_e'(in_req_i.action) == ACT_POP_FRONT) begin
            front_d = step_up(front_q);
            count_d = count_q - CntW'(1);
          end
        end
      end
      ACT_POP_BACK, ACT_PEEK_BACK: begin
        if (is_empty) begin
          status = STAT_EMPTY;
        end else begin
          need_rd = 1'b1;
          rd_addr = step_down(back_q);
          if (action_e'(in_req_i.action) == ACT_POP_BACK) begin
            back_d  = step_down(back_q);
            count_d = count_q - CntW'(1);
          end
        end
      end
      ACT_CLEAR: begin
        front_d = '0;
        back_d  = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign imm_data   = (status == STAT_EMPTY) ? '1 : '0;
  assign count_wide = (CntW + CountW)'(count_d);

  always_comb begin
    state_d     = state_q;
    rsp_d       = rsp_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rsp_d.data       = imm_data;
          rsp_d.status     = status;
          rsp_d.count      = count_wide[CountW-1:0];
          rsp_d.empty_flag = (count_d == '0);
          rsp_d.full_flag  = (count_d == CntW'(DEPTH));
          if (need_rd) begin
            state_d = ST_READ;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      ST_READ: begin
        rsp_d.data  = rd_data;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      back_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        front_q <= front_d;
        back_q  <= back_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  cdq_ring #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (accept && wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_word),
    .rd_en_i   (accept && need_rd),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_word)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

/* src/cdq_checker.sv */
// Port-level checks for the circular deque unit, bound to its top level.
// Depends on cdq_pkg and on the ports of circular_deque_unit.
module cdq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input cdq_pkg::cdq_req_t in_req_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input cdq_pkg::cdq_rsp_t out_rsp_o
);

  import cdq_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_req_i))
    else $error("Stalled request changed or dropped.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("Stalled result changed or dropped.");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("Request taken while the result register is blocked.");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == STAT_EMPTY
      |-> out_rsp_o.data == '1 && out_rsp_o.empty_flag)
    else $error("Empty status without the empty word and flag.");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == STAT_FULL
      |-> out_rsp_o.full_flag && out_rsp_o.data == '0)
    else $error("Full status without the full flag.");

endmodule

bind circular_deque_unit cdq_checker u_cdq_checker (.*);

/* test/cdq_tb_pkg.sv */
// Scoreboard for the circular deque unit testbench: a mirror of the deque that
// predicts each response, and the queue of responses still awaited.
// Depends on cdq_pkg for the request, response, action and status types.
`timescale 1ns / 1ps

package cdq_tb_pkg;
  import cdq_pkg::*;

  localparam int unsigned MirrorDepth = cdq_pkg::DepthDefault;

  class deque_mirror;
    logic signed [DataW-1:0] words [MirrorDepth];
    int unsigned             head_idx;
    int unsigned             tail_idx;
    int unsigned             fill;
    cdq_rsp_t                awaited_rsp [$];
    int                      errors;

    function new();
      head_idx = 0;
      tail_idx = 0;
      fill     = 0;
      errors   = 0;
    endfunction

    function void track_request(cdq_req_t req);
      cdq_rsp_t rsp;
      rsp = '0;
      case (req.action) inside
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          if (fill == MirrorDepth) begin
            rsp.status = STAT_FULL;
          end else if (req.action == ACT_PUSH_FRONT) begin
            head_idx = (head_idx + MirrorDepth - 1) % MirrorDepth;
            words[head_idx] = req.value;
            fill++;
          end else begin
            words[tail_idx] = req.value;
            tail_idx = (tail_idx + 1) % MirrorDepth;
            fill++;
          end
        end
        ACT_POP_FRONT, ACT_PEEK_FRONT: begin
          if (fill == 0) begin
            rsp.data   = -1;
            rsp.status = STAT_EMPTY;
          end else begin
            rsp.data = words[head_idx];
            if (req.action == ACT_POP_FRONT) begin
              head_idx = (head_idx + 1) % MirrorDepth;
              fill--;
            end
          end
        end
        ACT_POP_BACK, ACT_PEEK_BACK: begin
          if (fill == 0) begin
            rsp.data   = -1;
            rsp.status = STAT_EMPTY;
          end else begin
            rsp.data = words[(tail_idx + MirrorDepth - 1) % MirrorDepth];
            if (req.action == ACT_POP_BACK) begin
              tail_idx = (tail_idx + MirrorDepth - 1) % MirrorDepth;
              fill--;
            end
          end
        end
        ACT_CLEAR: begin
          fill     = 0;
          head_idx = 0;
          tail_idx = 0;
        end
        default: begin
        end
      endcase
      rsp.count      = fill[CountW-1:0];
      rsp.empty_flag = (fill == 0);
      rsp.full_flag  = (fill == MirrorDepth);
      awaited_rsp.push_back(rsp);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
    endfunction

    function void check_response(cdq_rsp_t got);
      cdq_rsp_t want;
      if (awaited_rsp.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual data %0h status %0d count %0d",
                 $time, got.data, got.status, got.count);
        errors++;
        return;
      end
      want = awaited_rsp.pop_front();
      if (got.data !== want.data) report("data", want.data, got.data);
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.count !== want.count) report("count", want.count, got.count);
      if (got.empty_flag !== want.empty_flag) report("empty_flag", want.empty_flag, got.empty_flag);
      if (got.full_flag !== want.full_flag) report("full_flag", want.full_flag, got.full_flag);
    endfunction
  endclass

endpackage

/* test/circular_deque_unit_tb.sv */
// Testbench top for circular_deque_unit: directed and biased random requests
// under random idling on both channels, then with no idling, checked against the deque mirror.
// Depends on cdq_pkg, cdq_tb_pkg and the circular_deque_unit RTL.
`timescale 1ns / 1ps

module circular_deque_unit_tb;
  import cdq_pkg::*;
  import cdq_tb_pkg::*;

  localparam logic [2:0] ActNop    = 3'd7;
  localparam int         BiasFill  = 0;
  localparam int         BiasDrain = 1;
  localparam int         BiasMixed = 2;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid;
  logic     in_stall_o;
  cdq_req_t in_req;
  logic     out_valid_o;
  logic     out_stall;
  cdq_rsp_t out_rsp_o;

  int          send_idle_pct;
  int          recv_idle_pct;
  deque_mirror mirror;

  circular_deque_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp_o)
  );

  initial clk_i = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      mirror.check_response(out_rsp_o);
    end
  end

  function automatic cdq_req_t make_req(input logic [2:0] act, input logic [31:0] val);
    cdq_req_t req;
    req.action = act;
    req.value  = val;
    return req;
  endfunction

  function automatic logic [31:0] draw_word();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [2:0] draw_action(input int bias);
    int push_w;
    int pop_w;
    int roll;
    case (bias)
      BiasFill: begin
        push_w = 70;
        pop_w  = 12;
      end
      BiasDrain: begin
        push_w = 14;
        pop_w  = 68;
      end
      default: begin
        push_w = 42;
        pop_w  = 42;
      end
    endcase
    roll = $urandom_range(99);
    if (roll < push_w) return $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    if (roll < push_w + pop_w) return $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
    if (roll < 96) return $urandom_range(1) ? ACT_PEEK_BACK : ACT_PEEK_FRONT;
    if (roll < 98) return ACT_CLEAR;
    return ActNop;
  endfunction

  task automatic send_request(input cdq_req_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk_i); while (in_stall_o);
    mirror.track_request(req);
    @(negedge clk_i);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (mirror.awaited_rsp.size() != 0) @(negedge clk_i);
  endtask

  task automatic run_directed();
    logic [31:0] extremes [4];
    extremes = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff};
    send_request(make_req(ACT_POP_FRONT, 32'h0));
    send_request(make_req(ACT_PEEK_BACK, 32'hffff_ffff));
    for (int i = 0; i < MirrorDepth; i++) begin
      send_request(make_req(i[0] ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
                            (i < 4) ? extremes[i] : $urandom()));
    end
    send_request(make_req(ACT_PUSH_BACK, 32'h1234_5678));
    send_request(make_req(ACT_PEEK_FRONT, 32'h0));
    send_request(make_req(ACT_PEEK_BACK, 32'h0));
    send_request(make_req(ACT_POP_FRONT, 32'h0));
    send_request(make_req(ACT_POP_BACK, 32'h0));
    send_request(make_req(ActNop, 32'hdead_beef));
    send_request(make_req(ACT_CLEAR, 32'h0));
    send_request(make_req(ACT_POP_BACK, 32'h0));
  endtask

  task automatic run_random(input int total);
    int sent;
    int seg_left;
    int bias;
    sent = 0;
    while (sent < total) begin
      bias     = $urandom_range(BiasMixed);
      seg_left = $urandom_range(60, 15);
      if ($urandom_range(9) == 0) wait_for_drain();
      while (seg_left > 0 && sent < total) begin
        send_request(make_req(draw_action(bias), draw_word()));
        sent++;
        seg_left--;
      end
    end
  endtask

  initial begin
    mirror        = new();
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_req        = '0;
    out_stall     = 1'b0;
    send_idle_pct = 25;
    recv_idle_pct = 63;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    run_random(630);
    wait_for_drain();

    send_idle_pct = 63;
    recv_idle_pct = 25;
    run_random(650);
    wait_for_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(650);

    in_valid <= 1'b0;
    while (mirror.awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mirror.errors == 0 && mirror.awaited_rsp.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* circular_deque_unit.f */
src/cdq_pkg.sv
src/cdq_ring.sv
src/circular_deque_unit.sv
src/cdq_checker.sv
test/cdq_tb_pkg.sv
test/circular_deque_unit_tb.sv
